// ===== design/cpu6502_eu_pkg.sv =====
// Package with operation codes, flag positions and shared types of the execute unit.
package cpu6502_eu_pkg;

    localparam int QueueDepth = 2;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
        OP_STX = 6'd4,  OP_STY = 6'd5,  OP_TAX = 6'd6,  OP_TAY = 6'd7,
        OP_TXA = 6'd8,  OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11,
        OP_ADC = 6'd12, OP_SBC = 6'd13, OP_INC = 6'd14, OP_DEC = 6'd15,
        OP_INX = 6'd16, OP_DEX = 6'd17, OP_INY = 6'd18, OP_DEY = 6'd19,
        OP_AND = 6'd20, OP_ORA = 6'd21, OP_EOR = 6'd22, OP_BIT = 6'd23,
        OP_ASL = 6'd24, OP_LSR = 6'd25, OP_ROL = 6'd26, OP_ROR = 6'd27,
        OP_BCC = 6'd28, OP_BCS = 6'd29, OP_BEQ = 6'd30, OP_BNE = 6'd31,
        OP_BMI = 6'd32, OP_BPL = 6'd33, OP_BVC = 6'd34, OP_BVS = 6'd35,
        OP_PHA = 6'd36, OP_PHP = 6'd37, OP_PLA = 6'd38, OP_PLP = 6'd39,
        OP_CLC = 6'd40, OP_SEC = 6'd41, OP_CLI = 6'd42, OP_SEI = 6'd43,
        OP_CLD = 6'd44, OP_SED = 6'd45, OP_CLV = 6'd46, OP_CMP = 6'd47,
        OP_CPX = 6'd48, OP_CPY = 6'd49, OP_NOP = 6'd50, OP_LAX = 6'd51,
        OP_SAX = 6'd52, OP_DCP = 6'd53, OP_ISC = 6'd54, OP_SLO = 6'd55,
        OP_RLA = 6'd56, OP_SRE = 6'd57, OP_RRA = 6'd58, OP_ANC = 6'd59,
        OP_ALR = 6'd60, OP_ARR = 6'd61, OP_SBX = 6'd62, OP_UNUSED = 6'd63
    } t_op;

    localparam int FlagC = 0;
    localparam int FlagZ = 1;
    localparam int FlagI = 2;
    localparam int FlagD = 3;
    localparam int FlagB = 4;
    localparam int FlagU = 5;
    localparam int FlagV = 6;
    localparam int FlagN = 7;

    localparam logic [7:0] SpReset     = 8'hFD;
    localparam logic [7:0] StatusReset = 8'h24;

    // Decoded item passed from the front end to the back end.
    typedef struct packed {
        t_op        op;
        logic [7:0] operand;
        logic       on_acc;
        logic       is_branch;
        logic       is_store;
    } t_item;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] xreg;
        logic [7:0] yreg;
        logic [7:0] sp;
        logic [7:0] status;
        logic [7:0] store_value;
        logic       store_enable;
        logic       branch_taken;
    } t_result;

endpackage

// ===== design/cpu6502_eu_front.sv =====
// Front end: accepts operations, classifies them and queues them for the back end.
module cpu6502_eu_front #(
    parameter int DEPTH = cpu6502_eu_pkg::QueueDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [5:0]            i_op,
    input  logic [7:0]            i_operand,
    input  logic                  i_on_acc,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cpu6502_eu_pkg::t_item o_item
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cpu6502_eu_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    cpu6502_eu_pkg::t_item w_item;
    logic w_push, w_pop;

    always_comb begin
        w_item.op        = cpu6502_eu_pkg::t_op'(i_op);
        w_item.operand   = i_operand;
        w_item.on_acc    = i_on_acc;
        w_item.is_branch = (i_op >= cpu6502_eu_pkg::OP_BCC) &&
                           (i_op <= cpu6502_eu_pkg::OP_BVS);
        unique case (cpu6502_eu_pkg::t_op'(i_op))
            cpu6502_eu_pkg::OP_STA, cpu6502_eu_pkg::OP_STX, cpu6502_eu_pkg::OP_STY,
            cpu6502_eu_pkg::OP_INC, cpu6502_eu_pkg::OP_DEC, cpu6502_eu_pkg::OP_PHA,
            cpu6502_eu_pkg::OP_PHP, cpu6502_eu_pkg::OP_SAX, cpu6502_eu_pkg::OP_DCP,
            cpu6502_eu_pkg::OP_ISC, cpu6502_eu_pkg::OP_SLO, cpu6502_eu_pkg::OP_RLA,
            cpu6502_eu_pkg::OP_SRE, cpu6502_eu_pkg::OP_RRA:
                w_item.is_store = 1'b1;
            cpu6502_eu_pkg::OP_ASL, cpu6502_eu_pkg::OP_LSR, cpu6502_eu_pkg::OP_ROL,
            cpu6502_eu_pkg::OP_ROR:
                w_item.is_store = !i_on_acc;
            default:
                w_item.is_store = 1'b0;
        endcase
    end

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end
endmodule

// ===== design/cpu6502_eu_back.sv =====
// Back end: holds the register file and flags, runs the ALU and registers the result.
module cpu6502_eu_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  cpu6502_eu_pkg::t_item   i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output cpu6502_eu_pkg::t_result o_result
);
    logic [7:0] r_a, r_x, r_y, r_sp, r_p;
    logic [7:0] n_a, n_x, n_y, n_sp, n_p, w_sv;
    logic       w_br;
    logic       r_valid;
    cpu6502_eu_pkg::t_result r_res;
    logic [7:0] m, src, r, t;
    logic [8:0] sum, add_v;
    logic       c, do_add;
    logic       w_fire;

    assign o_ready  = !r_valid || i_ready;
    assign w_fire   = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    always_comb begin
        m      = i_item.operand;
        c      = r_p[cpu6502_eu_pkg::FlagC];
        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p;
        w_sv   = 8'h00;
        w_br   = 1'b0;
        src    = i_item.on_acc ? r_a : m;
        r      = 8'h00;
        t      = 8'h00;
        do_add = 1'b0;
        add_v  = 9'h000;
        unique case (i_item.op)
            cpu6502_eu_pkg::OP_LDA, cpu6502_eu_pkg::OP_PLA: n_a = m;
            cpu6502_eu_pkg::OP_LDX: n_x = m;
            cpu6502_eu_pkg::OP_LDY: n_y = m;
            cpu6502_eu_pkg::OP_STA, cpu6502_eu_pkg::OP_PHA: w_sv = r_a;
            cpu6502_eu_pkg::OP_STX: w_sv = r_x;
            cpu6502_eu_pkg::OP_STY: w_sv = r_y;
            cpu6502_eu_pkg::OP_TAX: n_x = r_a;
            cpu6502_eu_pkg::OP_TAY: n_y = r_a;
            cpu6502_eu_pkg::OP_TXA: n_a = r_x;
            cpu6502_eu_pkg::OP_TYA: n_a = r_y;
            cpu6502_eu_pkg::OP_TSX: n_x = r_sp;
            cpu6502_eu_pkg::OP_TXS: n_sp = r_x;
            cpu6502_eu_pkg::OP_ADC: begin do_add = 1'b1; add_v = {1'b0, m}; end
            cpu6502_eu_pkg::OP_SBC: begin do_add = 1'b1; add_v = {1'b0, ~m}; end
            cpu6502_eu_pkg::OP_INC: w_sv = m + 8'd1;
            cpu6502_eu_pkg::OP_DEC: w_sv = m - 8'd1;
            cpu6502_eu_pkg::OP_INX: n_x = r_x + 8'd1;
            cpu6502_eu_pkg::OP_DEX: n_x = r_x - 8'd1;
            cpu6502_eu_pkg::OP_INY: n_y = r_y + 8'd1;
            cpu6502_eu_pkg::OP_DEY: n_y = r_y - 8'd1;
            cpu6502_eu_pkg::OP_AND: n_a = r_a & m;
            cpu6502_eu_pkg::OP_ORA: n_a = r_a | m;
            cpu6502_eu_pkg::OP_EOR: n_a = r_a ^ m;
            cpu6502_eu_pkg::OP_BIT: begin
                n_p[cpu6502_eu_pkg::FlagZ] = ((r_a & m) == 8'h00);
                n_p[cpu6502_eu_pkg::FlagV] = m[6];
                n_p[cpu6502_eu_pkg::FlagN] = m[7];
            end
            cpu6502_eu_pkg::OP_ASL, cpu6502_eu_pkg::OP_LSR,
            cpu6502_eu_pkg::OP_ROL, cpu6502_eu_pkg::OP_ROR: begin
                if (i_item.op == cpu6502_eu_pkg::OP_ASL) r = {src[6:0], 1'b0};
                else if (i_item.op == cpu6502_eu_pkg::OP_LSR) r = {1'b0, src[7:1]};
                else if (i_item.op == cpu6502_eu_pkg::OP_ROL) r = {src[6:0], c};
                else r = {c, src[7:1]};
                n_p[cpu6502_eu_pkg::FlagC] = (i_item.op == cpu6502_eu_pkg::OP_ASL ||
                    i_item.op == cpu6502_eu_pkg::OP_ROL) ? src[7] : src[0];
                if (i_item.on_acc) n_a = r;
                else w_sv = r;
            end
            cpu6502_eu_pkg::OP_BCC: w_br = !r_p[cpu6502_eu_pkg::FlagC];
            cpu6502_eu_pkg::OP_BCS: w_br = r_p[cpu6502_eu_pkg::FlagC];
            cpu6502_eu_pkg::OP_BEQ: w_br = r_p[cpu6502_eu_pkg::FlagZ];
            cpu6502_eu_pkg::OP_BNE: w_br = !r_p[cpu6502_eu_pkg::FlagZ];
            cpu6502_eu_pkg::OP_BMI: w_br = r_p[cpu6502_eu_pkg::FlagN];
            cpu6502_eu_pkg::OP_BPL: w_br = !r_p[cpu6502_eu_pkg::FlagN];
            cpu6502_eu_pkg::OP_BVC: w_br = !r_p[cpu6502_eu_pkg::FlagV];
            cpu6502_eu_pkg::OP_BVS: w_br = r_p[cpu6502_eu_pkg::FlagV];
            cpu6502_eu_pkg::OP_PHP: w_sv = r_p | 8'h30;
            cpu6502_eu_pkg::OP_PLP: n_p = (m & 8'hEF) | 8'h20;
            cpu6502_eu_pkg::OP_CLC: n_p[cpu6502_eu_pkg::FlagC] = 1'b0;
            cpu6502_eu_pkg::OP_SEC: n_p[cpu6502_eu_pkg::FlagC] = 1'b1;
            cpu6502_eu_pkg::OP_CLI: n_p[cpu6502_eu_pkg::FlagI] = 1'b0;
            cpu6502_eu_pkg::OP_SEI: n_p[cpu6502_eu_pkg::FlagI] = 1'b1;
            cpu6502_eu_pkg::OP_CLD: n_p[cpu6502_eu_pkg::FlagD] = 1'b0;
            cpu6502_eu_pkg::OP_SED: n_p[cpu6502_eu_pkg::FlagD] = 1'b1;
            cpu6502_eu_pkg::OP_CLV: n_p[cpu6502_eu_pkg::FlagV] = 1'b0;
            cpu6502_eu_pkg::OP_CMP, cpu6502_eu_pkg::OP_CPX, cpu6502_eu_pkg::OP_CPY,
            cpu6502_eu_pkg::OP_DCP: begin
                if (i_item.op == cpu6502_eu_pkg::OP_CPX) src = r_x;
                else if (i_item.op == cpu6502_eu_pkg::OP_CPY) src = r_y;
                else src = r_a;
                t = (i_item.op == cpu6502_eu_pkg::OP_DCP) ? m - 8'd1 : m;
                if (i_item.op == cpu6502_eu_pkg::OP_DCP) w_sv = t;
                r = src - t;
                n_p[cpu6502_eu_pkg::FlagC] = (src >= t);
                n_p[cpu6502_eu_pkg::FlagZ] = (r == 8'h00);
                n_p[cpu6502_eu_pkg::FlagN] = r[7];
            end
            cpu6502_eu_pkg::OP_LAX: begin n_a = m; n_x = m; end
            cpu6502_eu_pkg::OP_SAX: w_sv = r_a & r_x;
            cpu6502_eu_pkg::OP_ISC: begin
                w_sv = m + 8'd1; do_add = 1'b1; add_v = {1'b0, ~w_sv};
            end
            cpu6502_eu_pkg::OP_SLO: begin
                n_p[cpu6502_eu_pkg::FlagC] = m[7]; w_sv = {m[6:0], 1'b0}; n_a = r_a | w_sv;
            end
            cpu6502_eu_pkg::OP_RLA: begin
                n_p[cpu6502_eu_pkg::FlagC] = m[7]; w_sv = {m[6:0], c}; n_a = r_a & w_sv;
            end
            cpu6502_eu_pkg::OP_SRE: begin
                n_p[cpu6502_eu_pkg::FlagC] = m[0]; w_sv = {1'b0, m[7:1]}; n_a = r_a ^ w_sv;
            end
            cpu6502_eu_pkg::OP_RRA: begin
                // The carry used by the add is the one shifted out of the operand.
                n_p[cpu6502_eu_pkg::FlagC] = m[0]; w_sv = {c, m[7:1]};
                do_add = 1'b1; add_v = {1'b0, w_sv};
            end
            cpu6502_eu_pkg::OP_ANC: begin
                n_a = r_a & m; n_p[cpu6502_eu_pkg::FlagC] = n_a[7];
            end
            cpu6502_eu_pkg::OP_ALR: begin
                t = r_a & m; n_p[cpu6502_eu_pkg::FlagC] = t[0]; n_a = {1'b0, t[7:1]};
            end
            cpu6502_eu_pkg::OP_ARR: begin
                t = r_a & m; n_a = {c, t[7:1]};
                n_p[cpu6502_eu_pkg::FlagC] = n_a[6];
                n_p[cpu6502_eu_pkg::FlagV] = n_a[6] ^ n_a[5];
            end
            cpu6502_eu_pkg::OP_SBX: begin
                t = r_a & r_x; n_p[cpu6502_eu_pkg::FlagC] = (t >= m); n_x = t - m;
            end
            default: ;
        endcase
        if (do_add) begin
            sum = {1'b0, r_a} + add_v + {8'h00, n_p[cpu6502_eu_pkg::FlagC]};
            n_a = sum[7:0];
            n_p[cpu6502_eu_pkg::FlagC] = sum[8];
            n_p[cpu6502_eu_pkg::FlagV] = ~(r_a[7] ^ add_v[7]) & (r_a[7] ^ sum[7]);
        end else begin
            sum = 9'h000;
        end
        // Zero and negative follow whichever byte the operation produced.
        unique case (i_item.op)
            cpu6502_eu_pkg::OP_LDA, cpu6502_eu_pkg::OP_TXA, cpu6502_eu_pkg::OP_TYA,
            cpu6502_eu_pkg::OP_ADC, cpu6502_eu_pkg::OP_SBC, cpu6502_eu_pkg::OP_AND,
            cpu6502_eu_pkg::OP_ORA, cpu6502_eu_pkg::OP_EOR, cpu6502_eu_pkg::OP_PLA,
            cpu6502_eu_pkg::OP_LAX, cpu6502_eu_pkg::OP_ISC, cpu6502_eu_pkg::OP_SLO,
            cpu6502_eu_pkg::OP_RLA, cpu6502_eu_pkg::OP_SRE, cpu6502_eu_pkg::OP_RRA,
            cpu6502_eu_pkg::OP_ANC, cpu6502_eu_pkg::OP_ALR, cpu6502_eu_pkg::OP_ARR: begin
                n_p[cpu6502_eu_pkg::FlagZ] = (n_a == 8'h00);
                n_p[cpu6502_eu_pkg::FlagN] = n_a[7];
            end
            cpu6502_eu_pkg::OP_LDX, cpu6502_eu_pkg::OP_TAX, cpu6502_eu_pkg::OP_TSX,
            cpu6502_eu_pkg::OP_INX, cpu6502_eu_pkg::OP_DEX, cpu6502_eu_pkg::OP_SBX: begin
                n_p[cpu6502_eu_pkg::FlagZ] = (n_x == 8'h00);
                n_p[cpu6502_eu_pkg::FlagN] = n_x[7];
            end
            cpu6502_eu_pkg::OP_LDY, cpu6502_eu_pkg::OP_TAY,
            cpu6502_eu_pkg::OP_INY, cpu6502_eu_pkg::OP_DEY: begin
                n_p[cpu6502_eu_pkg::FlagZ] = (n_y == 8'h00);
                n_p[cpu6502_eu_pkg::FlagN] = n_y[7];
            end
            cpu6502_eu_pkg::OP_INC, cpu6502_eu_pkg::OP_DEC: begin
                n_p[cpu6502_eu_pkg::FlagZ] = (w_sv == 8'h00);
                n_p[cpu6502_eu_pkg::FlagN] = w_sv[7];
            end
            cpu6502_eu_pkg::OP_ASL, cpu6502_eu_pkg::OP_LSR,
            cpu6502_eu_pkg::OP_ROL, cpu6502_eu_pkg::OP_ROR: begin
                n_p[cpu6502_eu_pkg::FlagZ] = (r == 8'h00);
                n_p[cpu6502_eu_pkg::FlagN] = r[7];
            end
            default: ;
        endcase
        if (!i_item.is_store) w_sv = 8'h00;
        if (!i_item.is_branch) w_br = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res.acc          <= n_a;
            r_res.xreg         <= n_x;
            r_res.yreg         <= n_y;
            r_res.sp           <= n_sp;
            r_res.status       <= n_p;
            r_res.store_value  <= w_sv;
            r_res.store_enable <= i_item.is_store;
            r_res.branch_taken <= w_br;
        end
        if (!i_rst_n) begin
            r_a     <= 8'h00;
            r_x     <= 8'h00;
            r_y     <= 8'h00;
            r_sp    <= cpu6502_eu_pkg::SpReset;
            r_p     <= cpu6502_eu_pkg::StatusReset;
            r_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_a  <= n_a;
                r_x  <= n_x;
                r_y  <= n_y;
                r_sp <= n_sp;
                r_p  <= n_p;
            end
            if (w_fire) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end
endmodule

// ===== design/cpu6502_execute_unit_top.sv =====
// Top level of the 6502 execute unit: input queue front end and register/ALU back end.
// Each transaction is one decoded operation with its operand byte; one result transaction
// follows for each. The unit sustains one operation per clock unless the output stalls:
// the back end executes an operation through its 8-bit ALU, whose register and flag
// feedback is combinational, and the result appears in the cycle after the operation
// leaves the queue. A short input queue and the result register let either side stall
// independently.
module cpu6502_execute_unit_top #(
    parameter int QUEUE_DEPTH = cpu6502_eu_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // op[5:0], operand[13:6], on_accumulator[14], zero[15]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // acc_out[7:0], xreg_out[15:8], yreg_out[23:16], sp_out[31:24], status_out[39:32],
    // store_value[47:40], store_enable[48], branch_taken[49], zero[55:50]
    output logic [55:0] m_axis_tdata
);
    logic                    w_q_valid, w_q_ready;
    cpu6502_eu_pkg::t_item   w_item;
    cpu6502_eu_pkg::t_result w_res;

    cpu6502_eu_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_op      (s_axis_tdata[5:0]),
        .i_operand (s_axis_tdata[13:6]),
        .i_on_acc  (s_axis_tdata[14]),
        .o_valid   (w_q_valid),
        .i_ready   (w_q_ready),
        .o_item    (w_item)
    );

    cpu6502_eu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_item   (w_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    assign m_axis_tdata = {6'b000000, w_res.branch_taken, w_res.store_enable,
                           w_res.store_value, w_res.status, w_res.sp,
                           w_res.yreg, w_res.xreg, w_res.acc};
endmodule
